// ===== rtl/cvtq_pkg.sv =====
// Package for the binary128 converter: format codes, field constants and
// the leading-one search helper. No dependencies.
package cvtq_pkg;

  typedef enum logic [3:0] {
    CMD_S8  = 4'd0,
    CMD_U8  = 4'd1,
    CMD_S16 = 4'd2,
    CMD_U16 = 4'd3,
    CMD_S32 = 4'd4,
    CMD_U32 = 4'd5,
    CMD_S64 = 4'd6,
    CMD_U64 = 4'd7,
    CMD_DBL = 4'd8
  } cmd_e;

  localparam int unsigned CmdW  = 4;
  localparam int unsigned WordW = 64;
  localparam logic [14:0] QBias = 15'd16383;
  localparam logic [14:0] DBiasDiff = 15'd15360;  // 16383 - 1023
  localparam logic [14:0] QExpMax = 15'h7fff;

  // Position of the most significant set bit; zero for zero input.
  function automatic logic [5:0] msb_pos(input logic [63:0] m);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

// ===== rtl/cvtq_core.sv =====
// Combinational conversion of one source word to a binary128 pattern.
// Depends on cvtq_pkg.
module cvtq_core import cvtq_pkg::*; (
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [WordW-1:0] src_i,
  output logic [63:0]      hi_o,
  output logic [63:0]      lo_o
);

  logic        is_int;
  logic        neg;
  logic [63:0] x;
  logic [63:0] mag;
  logic [63:0] norm_in;
  logic [5:0]  p;
  logic [63:0] shifted;
  logic [14:0] exp_int;
  logic        d_sgn;
  logic [10:0] d_exp;
  logic [51:0] d_frac;

  assign d_sgn  = src_i[63];
  assign d_exp  = src_i[62:52];
  assign d_frac = src_i[51:0];

  // Select width, sign- or zero-extend and take the magnitude.
  always_comb begin
    is_int = 1'b1;
    neg    = 1'b0;
    x      = 64'd0;
    case (cmd_i)
      CMD_S8:  begin x = {{56{src_i[7]}}, src_i[7:0]};   neg = src_i[7];  end
      CMD_U8:  x = {56'd0, src_i[7:0]};
      CMD_S16: begin x = {{48{src_i[15]}}, src_i[15:0]}; neg = src_i[15]; end
      CMD_U16: x = {48'd0, src_i[15:0]};
      CMD_S32: begin x = {{32{src_i[31]}}, src_i[31:0]}; neg = src_i[31]; end
      CMD_U32: x = {32'd0, src_i[31:0]};
      CMD_S64: begin x = src_i; neg = src_i[63]; end
      CMD_U64: x = src_i;
      default: is_int = 1'b0;
    endcase
    mag = neg ? (64'd0 - x) : x;
  end

  // One shared normaliser serves integers and double subnormals.
  assign norm_in = is_int ? mag : {12'd0, d_frac};
  assign p       = msb_pos(norm_in);
  assign shifted = norm_in << (6'd63 - p);
  assign exp_int = QBias + {9'd0, p};

  always_comb begin
    hi_o = 64'd0;
    lo_o = 64'd0;
    if (is_int) begin
      if (mag != 64'd0) begin
        hi_o = {neg, exp_int, shifted[62:15]};
        lo_o = {shifted[14:0], 49'd0};
      end
    end else if (cmd_i == CMD_DBL) begin
      if (d_exp == 11'd0) begin
        if (d_frac == 52'd0) begin
          hi_o = {d_sgn, 63'd0};
        end else begin
          // value 2^(p-1074): exponent 16383-1023-51+p
          hi_o = {d_sgn, 15'(DBiasDiff - 15'd51 + {9'd0, p}), shifted[62:15]};
          lo_o = {shifted[14:0], 49'd0};
        end
      end else if (d_exp == 11'h7ff) begin
        hi_o = {d_sgn, QExpMax, d_frac[51:4]};
        lo_o = {d_frac[3:0], 60'd0};
      end else begin
        hi_o = {d_sgn, 15'(DBiasDiff + {4'd0, d_exp}), d_frac[51:4]};
        lo_o = {d_frac[3:0], 60'd0};
      end
    end
  end

endmodule

// ===== rtl/convert_to_binary128.sv =====
// Top level of the integer/double to binary128 converter.
// Depends on cvtq_pkg and cvtq_core.
//
// Usage: the input stream carries a format selector and a 64-bit source
// word; the output stream carries the exact binary128 pattern.
// s_axis_tdata holds, from the lowest bit up: cmd (4 bits), source_bits
// (64 bits), then zero padding to 72 bits. m_axis_tdata holds quad_high
// (64 bits) and then quad_low (64 bits).
// Every transfer in produces exactly one transfer out. The conversion is
// done in one pass of logic between the input register and the result
// register; the result register captures the result and raises valid.
// One item is accepted in every cycle while the output flows.
// Throughput is one item a cycle, set by the two registers advancing
// together whenever the result is taken or the result register is empty.
// When the receiver stalls, results hold in the result register and the
// input register fills; the input side then deasserts tready until space
// frees up, so nothing is lost or repeated.
// Reset clears both valid flags; no result is presented until the first
// input transfer after reset.
module convert_to_binary128 import cvtq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // cmd[3:0], source_bits[67:4], pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // quad_high[63:0], quad_low[127:64]
);

  logic        in_vld_q, in_vld_d;
  logic [3:0]  cmd_q;
  logic [63:0] src_q;
  logic        out_vld_q, out_vld_d;
  logic [63:0] hi_q, lo_q;
  logic [63:0] hi_c, lo_c;
  logic        out_take;
  logic        adv;

  // The result register moves when empty or being drained.
  assign out_take = m_axis_tready || !out_vld_q;
  assign adv      = in_vld_q && out_take;
  // The input register can take a transfer when empty or moving forward.
  assign s_axis_tready = !in_vld_q || out_take;

  assign in_vld_d  = (s_axis_tvalid && s_axis_tready) || (in_vld_q && !out_take);
  assign out_vld_d = adv || (out_vld_q && !m_axis_tready);

  cvtq_core u_core (
    .cmd_i (cmd_q),
    .src_i (src_q),
    .hi_o  (hi_c),
    .lo_o  (lo_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[3:0];
      src_q <= s_axis_tdata[67:4];
    end
    if (adv) begin
      hi_q <= hi_c;
      lo_q <= lo_c;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {lo_q, hi_q};

`ifndef SYNTHESIS
  // A stalled result is never overwritten.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // A waiting item with a full, stalled output blocks new input.
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted with no room");
  // An accepted item reaches the input register.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted item lost");
`endif

endmodule
